// ===== sv/crc16_pkt_pkg.sv =====
// crc16_pkt_pkg: shared types, constants and the byte-wide crc step
// for the length-prefixed frame receiver; no dependencies
package crc16_pkt_pkg;

  localparam int unsigned MaxPayload = 256;
  localparam int unsigned CountW     = $clog2(MaxPayload + 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  IdleByte = 8'hFF;

  localparam logic [7:0]  StartMarkerRst  = 8'hAA;
  localparam logic [8:0]  PayloadLimitRst = 9'd256;
  localparam logic        SkipAllOnesRst  = 1'b1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CfgStartMarker  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPayloadLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSkipAllOnes  = 2'd2;

  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindGood     = 2'd1,
    KindCrcError = 2'd2,
    KindLenError = 2'd3
  } kind_e;

  // crc-16 ccitt, msb first, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/crc16_packet_deframer.sv =====
// crc16_packet_deframer: top level of the length-prefixed frame receiver
// depends on crc16_pkt_pkg for constants, the result kind type and the crc step
//
// Usage: bytes from the serial link enter on in_valid_i / rx_byte_i and are
// taken at an edge where in_stall_o is low. Each byte is parsed in the cycle
// it is taken: start marker, command, length low/high, payload, crc low/high.
// A payload byte, a closing good/mismatch report or a length error leaves as
// one request on out_valid_o plus the field ports, in the cycle after the byte
// was taken. One byte is taken every cycle while in_stall_o is low; the
// single output register is refilled in the same cycle it is drained. When
// the receiver holds out_stall_i high with a request pending, in_stall_o
// rises and the request stays unchanged; every byte then waits, whether or
// not it closes a request.
// Configuration writes (start marker, payload limit, idle-byte skip) are taken
// every cycle on cfg_valid_i; the user must make them only while the block is
// idle, which the block does not enforce. Reset clears the parser to hunting,
// the crc to 0xFFFF, the output register to empty, marker 0xAA, limit 256, skip on.
module crc16_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  byte_index_o,
  output logic [7:0]  command_code_o,
  output logic [15:0] frame_length_o,
  output logic [15:0] crc_received_o,
  output logic [15:0] crc_computed_o
);

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhCmd   = 3'd1;
  localparam logic [2:0] PhLenLo = 3'd2;
  localparam logic [2:0] PhLenHi = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhCrcLo = 3'd5;
  localparam logic [2:0] PhCrcHi = 3'd6;

  localparam int unsigned CntW = crc16_pkt_pkg::CountW;

  // configuration
  logic [7:0] start_marker_q;
  logic [8:0] payload_limit_q;
  logic       skip_all_ones_q;

  // parser state
  logic [2:0]      phase_q, phase_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [15:0]     len_q, len_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     hcrc_q, hcrc_d;

  // output register
  logic                 out_valid_q;
  crc16_pkt_pkg::kind_e kind_q, kind_d;
  logic [7:0]           data_q, data_d;
  logic [7:0]           idx_q, idx_d;
  logic [7:0]           ocmd_q, ocmd_d;
  logic [15:0]          olen_q, olen_d;
  logic [15:0]          orx_q, orx_d;
  logic [15:0]          ocomp_q, ocomp_d;

  logic        in_acc;
  logic        res_d;
  logic [15:0] crc_next;
  logic [15:0] len_full;
  logic [15:0] limit_eff;
  logic [15:0] cnt_inc;
  logic [15:0] cnt_ext;
  logic [15:0] crc_full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q  <= crc16_pkt_pkg::StartMarkerRst;
      payload_limit_q <= crc16_pkt_pkg::PayloadLimitRst;
      skip_all_ones_q <= crc16_pkt_pkg::SkipAllOnesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        crc16_pkt_pkg::CfgStartMarker:  start_marker_q  <= cfg_data_i[7:0];
        crc16_pkt_pkg::CfgPayloadLimit: payload_limit_q <= cfg_data_i;
        crc16_pkt_pkg::CfgSkipAllOnes:  skip_all_ones_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign crc_next = crc16_pkt_pkg::crc_feed(crc_q, rx_byte_i);
  assign len_full = {rx_byte_i, len_q[7:0]};
  assign crc_full = {rx_byte_i, hcrc_q[7:0]};
  assign cnt_ext  = 16'(cnt_q);
  assign cnt_inc  = cnt_ext + 16'd1;
  assign limit_eff = (16'(payload_limit_q) > 16'(crc16_pkt_pkg::MaxPayload)) ?
                     16'(crc16_pkt_pkg::MaxPayload) : 16'(payload_limit_q);

  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    hcrc_d  = hcrc_q;
    res_d   = 1'b0;
    kind_d  = crc16_pkt_pkg::KindPayload;
    data_d  = 8'd0;
    idx_d   = 8'd0;
    orx_d   = 16'd0;
    if (!(skip_all_ones_q && rx_byte_i == crc16_pkt_pkg::IdleByte)) begin
      case (phase_q)
        PhHunt: begin
          if (rx_byte_i == start_marker_q) begin
            phase_d = PhCmd;
            crc_d   = crc16_pkt_pkg::CrcInit;
            cmd_d   = 8'd0;
            len_d   = 16'd0;
            cnt_d   = '0;
            hcrc_d  = 16'd0;
          end
        end
        PhCmd: begin
          cmd_d   = rx_byte_i;
          crc_d   = crc_next;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          len_d   = {8'd0, rx_byte_i};
          crc_d   = crc_next;
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          len_d = len_full;
          crc_d = crc_next;
          cnt_d = '0;
          if (len_full > limit_eff) begin
            phase_d = PhHunt;
            res_d   = 1'b1;
            kind_d  = crc16_pkt_pkg::KindLenError;
          end else if (len_full == 16'd0) begin
            phase_d = PhCrcLo;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          crc_d  = crc_next;
          res_d  = 1'b1;
          kind_d = crc16_pkt_pkg::KindPayload;
          data_d = rx_byte_i;
          idx_d  = cnt_ext[7:0];
          cnt_d  = cnt_inc[CntW-1:0];
          if (cnt_inc >= len_q) begin
            phase_d = PhCrcLo;
          end
        end
        PhCrcLo: begin
          hcrc_d  = {8'd0, rx_byte_i};
          phase_d = PhCrcHi;
        end
        PhCrcHi: begin
          hcrc_d  = crc_full;
          phase_d = PhHunt;
          res_d   = 1'b1;
          orx_d   = crc_full;
          kind_d  = (crc_full == crc_q) ? crc16_pkt_pkg::KindGood :
                                          crc16_pkt_pkg::KindCrcError;
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
    ocmd_d  = cmd_d;
    olen_d  = len_d;
    ocomp_d = crc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      crc_q       <= crc16_pkt_pkg::CrcInit;
      cmd_q       <= 8'd0;
      len_q       <= 16'd0;
      cnt_q       <= '0;
      hcrc_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        crc_q   <= crc_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        hcrc_q  <= hcrc_d;
      end
      if (in_acc) begin
        out_valid_q <= res_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_d) begin
      kind_q  <= kind_d;
      data_q  <= data_d;
      idx_q   <= idx_d;
      ocmd_q  <= ocmd_d;
      olen_q  <= olen_d;
      orx_q   <= orx_d;
      ocomp_q <= ocomp_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign byte_index_o   = idx_q;
  assign command_code_o = ocmd_q;
  assign frame_length_o = olen_q;
  assign crc_received_o = orx_q;
  assign crc_computed_o = ocomp_q;

  a_good_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == crc16_pkt_pkg::KindGood |-> orx_q == ocomp_q)
    else $error("good frame reported with differing crc");

  a_bad_differs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == crc16_pkt_pkg::KindCrcError |-> orx_q != ocomp_q)
    else $error("crc mismatch reported with equal crc");

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> cnt_ext < len_q)
    else $error("payload count reached length inside data phase");

  a_len_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> len_q <= 16'(crc16_pkt_pkg::MaxPayload))
    else $error("data phase entered with oversized length");

  a_idle_no_move : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && skip_all_ones_q && rx_byte_i == crc16_pkt_pkg::IdleByte
    |=> $stable(phase_q) && $stable(crc_q) && !out_valid_q)
    else $error("idle byte changed parser state or produced a request");

endmodule
